@@ rtl/pptd_pkg.sv @@
// Package: types, codes and constants for the periodic priority task dispatcher.
package pptd_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int RESULT_CAP    = 16;
   localparam int EMIT_W        = $clog2(RESULT_CAP + 1);
   localparam int SLOT_W        = 4;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_ADD  = 2'd1,
      CMD_DEL  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DISPATCH = 3'd0,
      ST_NONE_DUE = 3'd1,
      ST_ADDED    = 3'd2,
      ST_DELETED  = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FULL     = 3'd5,
      ST_SKIPPED  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_T_RD, S_T_WR, S_T_END, S_S_RD, S_S_CMP, S_EMIT,
      S_D_RD, S_D_CMP, S_D_SRD, S_D_SWR
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [31:0]        now_ms;
      logic [15:0]        task_key;
      logic [30:0]        period;
      logic [31:0]        first_due;
      logic signed [15:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] dispatch_key;
      logic [3:0]  dispatch_slot;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        key;
      logic [30:0]        period;
      logic [31:0]        due;
      logic signed [15:0] prio;
   } entry_type;

endpackage

@@ rtl/periodic_priority_task_dispatcher.sv @@
// Top level: task table in one memory, sequential scan for due update and dispatch order.
// Add writes the new entry straight into the table. Tick first scans the table to advance
// the due entries, then rescans it once per dispatch to pick the highest-priority due task.
// Delete searches the entries for the key, then shifts each later entry down by one.
// One transaction is processed at a time; the memory is read one entry at a time.
// Synchronous active-high reset empties the table and clears the skip flag; entry contents
// are not reset.
module periodic_priority_task_dispatcher
   import pptd_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   entry_type mem [MAX_TASKS];
   entry_type rd_ff;
   logic           mem_we;
   logic [IW-1:0]  mem_wa, mem_ra;
   entry_type      mem_wd;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in, idx_ff, idx_in, ndue_ff, ndue_in;
   logic [EMIT_W-1:0]  emit_ff, emit_in;
   logic               skip_ff, skip_in, found_ff, found_in;
   logic [MAX_TASKS-1:0] due_ff, due_in;
   logic signed [15:0] best_prio_ff, best_prio_in;
   logic [15:0]        best_key_ff, best_key_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   status_type         pst_ff, pst_in;
   logic               plast_ff, plast_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      idx_p1;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ndue_ff      <= '0;
         due_ff       <= '0;
         emit_ff      <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         ndue_ff      <= ndue_in;
         due_ff       <= due_in;
         emit_ff      <= emit_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
      end
      best_prio_ff <= best_prio_in;
      best_key_ff  <= best_key_in;
      best_idx_ff  <= best_idx_in;
      pst_ff       <= pst_in;
      plast_ff     <= plast_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   assign idx_p1    = idx_ff + 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      skip_in      = skip_ff;
      ndue_in      = ndue_ff;
      due_in       = due_ff;
      emit_in      = emit_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_prio_in = best_prio_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      pst_in       = pst_ff;
      plast_in     = plast_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_wa       = idx_ff[IW-1:0];
      mem_wd       = rd_ff;
      mem_ra       = idx_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               plast_in = 1'b1;
               case (req_data.cmd)
                  CMD_TICK: begin
                     due_in   = '0;
                     ndue_in  = '0;
                     emit_in  = '0;
                     state_in = S_T_RD;
                  end
                  CMD_ADD: begin
                     if (cnt_ff >= CW'(MAX_TASKS)) begin
                        pst_in = ST_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        mem_wa      = cnt_ff[IW-1:0];
                        mem_wd.key  = req_data.task_key;
                        mem_wd.period = req_data.period;
                        mem_wd.due  = req_data.first_due;
                        mem_wd.prio = req_data.priority_req;
                        cnt_in      = cnt_ff + 1'b1;
                        pst_in      = ST_ADDED;
                     end
                     state_in = S_EMIT;
                  end
                  CMD_DEL: state_in = S_D_RD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_T_RD: begin
            state_in = (idx_ff >= cnt_ff) ? S_T_END : S_T_WR;
         end
         S_T_WR: begin
            if (rd_ff.due <= req_ff.now_ms) begin
               mem_we     = 1'b1;
               mem_wd.due = rd_ff.due + {1'b0, rd_ff.period};
               due_in[idx_ff[IW-1:0]] = 1'b1;
               ndue_in    = ndue_ff + 1'b1;
            end
            idx_in   = idx_p1;
            state_in = S_T_RD;
         end
         S_T_END: begin
            idx_in   = '0;
            found_in = 1'b0;
            plast_in = 1'b1;
            if (ndue_ff == '0) begin
               pst_in   = ST_NONE_DUE;
               state_in = S_EMIT;
            end else if (skip_ff) begin
               skip_in  = 1'b0;
               pst_in   = ST_SKIPPED;
               state_in = S_EMIT;
            end else begin
               state_in = S_S_RD;
            end
         end
         S_S_RD: begin
            if (idx_ff >= cnt_ff) begin
               pst_in   = ST_DISPATCH;
               plast_in = (ndue_ff == CW'(1)) ||
                          (emit_ff + 1'b1 == EMIT_W'(RESULT_CAP));
               state_in = S_EMIT;
            end else begin
               state_in = S_S_CMP;
            end
         end
         S_S_CMP: begin
            // >= lets the higher table position win a tie
            if (due_ff[idx_ff[IW-1:0]] && (!found_ff || rd_ff.prio >= best_prio_ff)) begin
               found_in     = 1'b1;
               best_prio_in = rd_ff.prio;
               best_key_in  = rd_ff.key;
               best_idx_in  = idx_ff[IW-1:0];
            end
            idx_in   = idx_p1;
            state_in = S_S_RD;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = pst_ff;
               rsp_in.last          = plast_ff;
               rsp_in.dispatch_key  = '0;
               rsp_in.dispatch_slot = '0;
               if (pst_ff == ST_DISPATCH) begin
                  rsp_in.dispatch_key  = best_key_ff;
                  rsp_in.dispatch_slot = SLOT_W'(best_idx_ff);
                  due_in[best_idx_ff]  = 1'b0;
                  ndue_in  = ndue_ff - 1'b1;
                  emit_in  = emit_ff + 1'b1;
               end
               idx_in   = '0;
               found_in = 1'b0;
               state_in = plast_ff ? S_IDLE : S_S_RD;
            end
         end
         S_D_RD: begin
            if (idx_ff >= cnt_ff) begin
               pst_in   = ST_NOT_FOUND;
               state_in = S_EMIT;
            end else begin
               state_in = S_D_CMP;
            end
         end
         S_D_CMP: begin
            if (rd_ff.key == req_ff.task_key) begin
               state_in = S_D_SRD;
            end else begin
               idx_in   = idx_p1;
               state_in = S_D_RD;
            end
         end
         S_D_SRD: begin
            // close the gap: entry idx+1 moves down to idx
            mem_ra = idx_p1[IW-1:0];
            if (idx_p1 >= cnt_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               skip_in  = 1'b1;
               pst_in   = ST_DELETED;
               state_in = S_EMIT;
            end else begin
               state_in = S_D_SWR;
            end
         end
         S_D_SWR: begin
            mem_we   = 1'b1;
            idx_in   = idx_p1;
            state_in = S_D_SRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_TASKS))
      else $error("task count above capacity");

   a_due_count: assert property (@(posedge clock) disable iff (reset)
      $countones(due_ff) == int'(ndue_ff))
      else $error("due counter out of step with due flags");

   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= EMIT_W'(RESULT_CAP))
      else $error("too many dispatches for one tick");

endmodule
